### hw/rtl/csts_pkg.sv
// ----------------------------------------------------------------------------
// csts_pkg: shared types and constants for the compacting id set table
// Sizes, operation and status codes, and the input and result item structs.
// ----------------------------------------------------------------------------
package csts_pkg;

  // Table capacity (1..16) and significant id width (8..64).
  localparam int SET_SIZE = 16;
  localparam int ID_WIDTH = 32;

  // Width of the id field on the ports; stored ids keep the narrower of the two.
  localparam int ID_FIELD_W = 32;
  localparam int ID_BITS    = (ID_WIDTH < ID_FIELD_W) ? ID_WIDTH : ID_FIELD_W;

  localparam int COUNT_W = $clog2(SET_SIZE + 1);
  localparam int SLOT_W  = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;

  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;
  localparam int POSITION_W = 4;
  localparam int ENTRY_CNT_W = 5;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RESERVED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  localparam logic [ID_FIELD_W-1:0] RESERVED_ID_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [ID_FIELD_W-1:0] id_value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic                   found;
    logic [POSITION_W-1:0]  position;
    logic [ENTRY_CNT_W-1:0] entry_count;
  } out_item_t;

  // Per-cell controls driven by the sequencer.
  typedef struct packed {
    logic occupied;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

### hw/rtl/compacting_id_set_table.sv
// ----------------------------------------------------------------------------
// compacting_id_set_table: fixed-capacity set of ids in insertion order
// A row of slot cells with a broadcast compare and a one-step compaction.
// ----------------------------------------------------------------------------
// Usage
//   in_data (op, id_value) is taken on a transfer: in_valid high, in_stall low.
//   Each transfer yields exactly one result on out_data (status, found,
//   position, entry_count), moved when out_valid is high and out_stall low.
//   cfg_valid/cfg_ready/cfg_data writes the reserved id; cfg_ready is
//   always high. Write it only while the table is idle.
// Timing
//   An item is captured at its transfer edge; in execute every cell
//   compares its id with the broadcast id and the hit is encoded; once the
//   output register is free the cells load or shift down and the result
//   lands in the output register. The next item is taken only after execute
//   completes, set by the capture/execute pair of the sequencer.
// Stalls
//   A waiting result does not block capture of the next item; that item
//   holds in execute until the output register frees up.
// Reset
//   rst clears the count, the sequencer and out_valid, and sets the reserved
//   id to all ones. Slot contents are not cleared; only slots below the count
//   are ever compared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module compacting_id_set_table (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  csts_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output csts_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [csts_pkg::ID_FIELD_W-1:0] cfg_data
);
  import csts_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                  state;
  logic                  state_next;
  logic [ID_FIELD_W-1:0] reserved_id;
  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    count_next;
  logic [OP_W-1:0]       cur_op;
  logic [ID_BITS-1:0]    cur_id;

  logic                  in_xfer;
  logic                  exec_fire;

  cell_ctrl_t            ctrl  [SET_SIZE];
  logic [ID_BITS-1:0]    entry [SET_SIZE];
  logic [ID_BITS-1:0]    upper [SET_SIZE];
  logic [SET_SIZE-1:0]   hit;

  logic                  is_reserved;
  logic                  found;
  logic [SLOT_W-1:0]     slot;
  logic                  add_ok;
  logic                  del_ok;
  logic [STATUS_W-1:0]   status;

  logic [SLOT_W+POSITION_W-1:0]   pos_ext;
  logic [COUNT_W+ENTRY_CNT_W-1:0] cnt_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state == S_EXEC);
  assign in_xfer   = in_valid && !in_stall;
  // Execute completes once the output register is empty or draining.
  assign exec_fire = (state == S_EXEC) && (!out_valid || !out_stall);

  // Cell row: each slot takes the id of the slot above when compacting.
  for (genvar i = 0; i < SET_SIZE; i++) begin : g_cell
    if (i == SET_SIZE - 1) begin : g_top
      assign upper[i] = '0;
    end else begin : g_mid
      assign upper[i] = entry[i+1];
    end

    assign ctrl[i].occupied = COUNT_W'(i) < count;
    assign ctrl[i].load     = exec_fire && add_ok && (count == COUNT_W'(i));
    assign ctrl[i].shift    = exec_fire && del_ok && (SLOT_W'(i) >= slot);

    csts_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl[i]),
      .id          (cur_id),
      .upper_entry (upper[i]),
      .entry       (entry[i]),
      .hit         (hit[i])
    );
  end

  assign is_reserved = (cur_id == reserved_id[ID_BITS-1:0]);
  assign found       = |hit;

  // Held ids are distinct, so at most one cell hits: OR the indexes.
  always_comb begin
    slot = '0;
    for (int i = 0; i < SET_SIZE; i++) begin
      if (hit[i]) begin
        slot = slot | SLOT_W'(i);
      end
    end
  end

  always_comb begin
    add_ok     = 1'b0;
    del_ok     = 1'b0;
    status     = ST_OK;
    count_next = count;
    if (is_reserved) begin
      status = ST_RESERVED;
    end else begin
      case (cur_op)
        OP_ADD: begin
          if (found) begin
            status = ST_DUPLICATE;
          end else if (count >= COUNT_W'(SET_SIZE)) begin
            status = ST_FULL;
          end else begin
            add_ok     = 1'b1;
            count_next = count + COUNT_W'(1);
          end
        end
        OP_DELETE: begin
          if (found) begin
            del_ok     = 1'b1;
            count_next = count - COUNT_W'(1);
          end else begin
            status = ST_NOT_FOUND;
          end
        end
        default: begin
          // query, and the unused code that behaves as one
          if (!found) begin
            status = ST_NOT_FOUND;
          end
        end
      endcase
    end
  end

  assign pos_ext = {{POSITION_W{1'b0}}, slot};
  assign cnt_ext = {{ENTRY_CNT_W{1'b0}}, count_next};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      out_valid   <= 1'b0;
      reserved_id <= RESERVED_ID_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        reserved_id <= cfg_data;
      end
      if (exec_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_op <= in_data.op;
      cur_id <= in_data.id_value[ID_BITS-1:0];
    end
    if (exec_fire) begin
      out_data.status      <= status;
      out_data.found       <= found && !is_reserved;
      out_data.position    <= (found && !is_reserved) ? pos_ext[POSITION_W-1:0] : '0;
      out_data.entry_count <= cnt_ext[ENTRY_CNT_W-1:0];
    end
  end

  // Count never passes capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(SET_SIZE))
    else $error("count exceeds table capacity");

  // A captured item always moves the sequencer to execute.
  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == S_EXEC))
    else $error("captured item not executed");

  // The count only changes when an item completes execute.
  a_count_quiet: assert property (@(posedge clk) disable iff (rst)
    !exec_fire |=> $stable(count))
    else $error("count changed outside execute");

  // Load and compaction never act together.
  a_no_load_shift: assert property (@(posedge clk) disable iff (rst)
    !(add_ok && del_ok))
    else $error("append and compaction requested together");

endmodule

### hw/rtl/csts_cell.sv
// ----------------------------------------------------------------------------
// csts_cell: one slot of the id table
// Holds one id, compares it against the broadcast id, and either loads the
// broadcast id or takes the id of the slot above when the table compacts.
// ----------------------------------------------------------------------------
module csts_cell (
  input  logic                     clk,
  input  csts_pkg::cell_ctrl_t     ctrl,
  input  logic [csts_pkg::ID_BITS-1:0] id,
  input  logic [csts_pkg::ID_BITS-1:0] upper_entry,
  output logic [csts_pkg::ID_BITS-1:0] entry,
  output logic                     hit
);
  import csts_pkg::*;

  logic [ID_BITS-1:0] entry_next;

  assign hit = ctrl.occupied && (entry == id);

  always_comb begin
    entry_next = entry;
    if (ctrl.load) begin
      entry_next = id;
    end else if (ctrl.shift) begin
      entry_next = upper_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### bench/tb_compacting_id_set_table.sv
// ----------------------------------------------------------------------------
// tb_compacting_id_set_table: self-checking bench for the id set table
// Directed rows, then random phases with adds, deletes, queries, the unused
// op code and reserved-id rewrites, checked against an in-bench set model.
// ----------------------------------------------------------------------------
module tb_compacting_id_set_table;
  import csts_pkg::*;

  // Op code 3 has no name in the package; the block treats it as a query.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Only the low ID_BITS of an id take part in the compare.
  localparam logic [ID_FIELD_W-1:0] ID_MASK = {ID_FIELD_W{1'b1}} >> (ID_FIELD_W - ID_BITS);

  localparam int POOL_N      = 24;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 150;
  localparam int CYCLE_LIMIT = 400000;

  // One directed row: the item, plus a hand-written result where it is obvious.
  typedef struct packed {
    in_item_t  item;
    logic      has_want;
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [ID_FIELD_W-1:0] cfg_data;

  // Set model state: held ids in slot order, their count, the no-id value.
  logic [ID_FIELD_W-1:0] held_ids [SET_SIZE];
  int                    held_count;
  logic [ID_FIELD_W-1:0] no_id;

  out_item_t             pending_results [$];
  out_item_t             head_result;
  dir_row_t              dir_rows [$];
  logic [ID_FIELD_W-1:0] id_pool [POOL_N];

  logic no_gaps;        // both sides run back to back while set
  int   mismatch_count;
  int   items_sent;
  int   results_seen;
  int   cfg_writes;
  int   cycles;
  int   status_hits [5];

  compacting_id_set_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run guard: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still owed",
               $time, cycles, pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Set model. Applies one operation to the held ids and returns the result.
  // Check order: reserved id first, then presence, then capacity.
  // --------------------------------------------------------------------------
  function automatic out_item_t predict_op(input in_item_t item);
    out_item_t             r;
    logic [ID_FIELD_W-1:0] key;
    int                    slot;
    r    = '0;
    key  = item.id_value & ID_MASK;
    slot = -1;
    for (int i = 0; i < held_count; i++)
      if (slot < 0 && held_ids[i] == key) slot = i;
    if (key == (no_id & ID_MASK)) begin
      // reserved id: rejected for any op, even if it sits in the table
      r.status = ST_RESERVED;
    end else if (slot >= 0) begin
      r.found    = 1'b1;
      r.position = POSITION_W'(slot);
      if (item.op == OP_ADD) begin
        r.status = ST_DUPLICATE;
      end else if (item.op == OP_DELETE) begin
        // close the gap: later entries move down one slot
        for (int i = slot; i + 1 < held_count; i++) held_ids[i] = held_ids[i + 1];
        held_count--;
      end
    end else if (item.op == OP_ADD) begin
      if (held_count >= SET_SIZE) begin
        r.status = ST_FULL;
      end else begin
        held_ids[held_count] = key;
        held_count++;
      end
    end else begin
      // delete, query and the unused code all miss here
      r.status = ST_NOT_FOUND;
    end
    r.entry_count = ENTRY_CNT_W'(held_count);
    return r;
  endfunction

  function automatic void dir_row(input logic [OP_W-1:0] op, input logic [ID_FIELD_W-1:0] id,
                                  input int has_want, input logic [STATUS_W-1:0] status,
                                  input int found, input int position,
                                  input int entry_count);
    dir_row_t r;
    r.item     = {op, id};
    r.has_want = 1'(has_want);
    r.want     = {status, 1'(found), POSITION_W'(position), ENTRY_CNT_W'(entry_count)};
    dir_rows.push_back(r);
  endfunction

  // Random item: mostly ids from a small pool or from the table, so that
  // hits, duplicates, deletes with compaction and full-table adds are common.
  function automatic in_item_t pick_item(input int add_pct);
    in_item_t it;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) it.op = OP_ADD;
    else if (roll < add_pct + (95 - add_pct) / 2) it.op = OP_DELETE;
    else if (roll < 95) it.op = OP_QUERY;
    else it.op = OP_UNUSED;
    if (it.op != OP_ADD && held_count > 0 && $urandom_range(0, 9) < 7)
      it.id_value = held_ids[$urandom_range(0, held_count - 1)];
    else if ($urandom_range(0, 19) == 0)
      it.id_value = $urandom;
    else
      it.id_value = id_pool[$urandom_range(0, POOL_N - 1)];
    return it;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: optional gap, then hold the item until a transfer happens.
  // The model runs at the transfer edge so the queue stays in order.
  // --------------------------------------------------------------------------
  task automatic send_item(input in_item_t item, input logic has_want, input out_item_t want);
    int        gap;
    out_item_t pred;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_op(item);
    pending_results.push_back(has_want ? want : pred);
    items_sent++;
  endtask

  // Every transfer yields a result, so an empty queue means the block is idle.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_no_id(input logic [ID_FIELD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    no_id = value;
    cfg_writes++;
  endtask

  // Receiver: draws a stall length per result, then takes one transfer.
  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Result checker: compares each transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.status < 5) status_hits[out_data.status]++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, out_data);
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("status", 32'(head_result.status), 32'(out_data.status));
        check_field("found", 32'(head_result.found), 32'(out_data.found));
        check_field("position", 32'(head_result.position), 32'(out_data.position));
        check_field("entry_count", 32'(head_result.entry_count),
                    32'(out_data.entry_count));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_item_t              it;
    logic [ID_FIELD_W-1:0] cfg_value;
    int                    add_pct [PHASES];
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    no_gaps        = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    results_seen   = 0;
    cfg_writes     = 0;
    cycles         = 0;
    held_count     = 0;
    no_id          = RESERVED_ID_RESET;
    foreach (status_hits[i]) status_hits[i] = 0;
    add_pct = '{70, 35, 60, 25, 75, 50, 65};

    // Directed rows, starting from reset with the no-id value all ones.
    dir_row(OP_QUERY,  32'h0000_0000, 1, ST_NOT_FOUND, 0, 0, 0);
    dir_row(OP_DELETE, 32'h0000_0000, 1, ST_NOT_FOUND, 0, 0, 0);
    dir_row(OP_ADD,    32'hFFFF_FFFF, 1, ST_RESERVED,  0, 0, 0);
    dir_row(OP_QUERY,  32'hFFFF_FFFF, 1, ST_RESERVED,  0, 0, 0);
    dir_row(OP_DELETE, 32'hFFFF_FFFF, 1, ST_RESERVED,  0, 0, 0);
    dir_row(OP_ADD,    32'h0000_0000, 1, ST_OK,        0, 0, 1);
    dir_row(OP_ADD,    32'h0000_0000, 1, ST_DUPLICATE, 1, 0, 1);
    dir_row(OP_ADD,    32'hFFFF_FFFE, 1, ST_OK,        0, 0, 2);
    dir_row(OP_ADD,    32'h8000_0000, 1, ST_OK,        0, 0, 3);
    dir_row(OP_ADD,    32'h7FFF_FFFF, 1, ST_OK,        0, 0, 4);
    dir_row(OP_QUERY,  32'h8000_0000, 0, ST_OK, 0, 0, 0);
    dir_row(OP_UNUSED, 32'hFFFF_FFFE, 0, ST_OK, 0, 0, 0);
    dir_row(OP_UNUSED, 32'h0000_1234, 1, ST_NOT_FOUND, 0, 0, 4);
    dir_row(OP_DELETE, 32'h0000_0000, 0, ST_OK, 0, 0, 0);  // head delete, all shift
    dir_row(OP_QUERY,  32'h7FFF_FFFF, 0, ST_OK, 0, 0, 0);
    dir_row(OP_DELETE, 32'h8000_0000, 0, ST_OK, 0, 0, 0);  // middle delete
    dir_row(OP_QUERY,  32'h7FFF_FFFF, 0, ST_OK, 0, 0, 0);
    dir_row(OP_DELETE, 32'h7FFF_FFFF, 0, ST_OK, 0, 0, 0);  // tail delete, no shift
    dir_row(OP_ADD,    32'h5555_AAAA, 0, ST_OK, 0, 0, 0);
    dir_row(OP_QUERY,  32'h0000_0000, 0, ST_OK, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].has_want, dir_rows[i].want);

    // Random phases: each starts idle with a fresh no-id value and id pool.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p % 4)
        0: cfg_value = '0;
        1: cfg_value = (held_count > 0) ? held_ids[$urandom_range(0, held_count - 1)]
                                        : $urandom;  // an id already held
        2: cfg_value = $urandom;
        default: cfg_value = '1;
      endcase
      write_no_id(cfg_value);
      id_pool[0] = no_id;
      id_pool[1] = '0;
      id_pool[2] = '1;
      id_pool[3] = 32'h8000_0000;
      id_pool[4] = 32'h0000_0001;
      for (int k = 5; k < POOL_N; k++) id_pool[k] = $urandom;
      no_gaps = (p == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p != 5 && n % 50 == 49) no_gaps = ($urandom_range(0, 3) == 0);
        it = pick_item(add_pct[p]);
        send_item(it, 1'b0, '0);
      end
    end
    no_gaps = 1'b0;

    drain();
    repeat (6) @(posedge clk);

    $display("ran %0d items, %0d results, %0d no-id writes",
             items_sent, results_seen, cfg_writes);
    $display("status mix: ok %0d, reserved %0d, duplicate %0d, full %0d, not found %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
